[hw/rtl/sst_pkg.sv]
package sst_pkg;

    localparam int MAX_LEAVES = 1024;
    localparam int NODE_DEPTH = 2 * MAX_LEAVES;
    localparam int NODE_AW    = $clog2(NODE_DEPTH);
    localparam int IDX_W      = NODE_AW + 1;
    localparam int DATA_W     = 32;
    localparam int LC_W       = 11;
    localparam int POS_W      = 10;
    localparam int OP_W       = 2;

    localparam logic [LC_W-1:0] LEAF_COUNT_RESET = LC_W'(1024);

    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd2;

    typedef logic [3:0] t_step;

    localparam t_step ST_CLR     = 4'd0;
    localparam t_step ST_IDLE    = 4'd1;
    localparam t_step ST_SET_WR  = 4'd2;
    localparam t_step ST_SET_TST = 4'd3;
    localparam t_step ST_SET_UPD = 4'd4;
    localparam t_step ST_Q_TST   = 4'd5;
    localparam t_step ST_Q_ADD   = 4'd6;
    localparam t_step ST_B_TST   = 4'd7;
    localparam t_step ST_B_WR    = 4'd8;
    localparam t_step ST_FIN     = 4'd9;
    localparam t_step ST_FIN_Z   = 4'd10;

    typedef enum logic [1:0] {RD_NONE, RD_SIB, RD_Q, RD_B} t_rd_mode;
    typedef enum logic [2:0] {WR_NONE, WR_CLR, WR_LEAF, WR_SET, WR_BLD} t_wr_mode;
    typedef enum logic [2:0] {K_HOLD, K_INC, K_HALF, K_DEC, K_QSTEP, K_LOAD} t_k_mode;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_SET, ACC_Q} t_acc_mode;
    typedef enum logic [1:0] {OUT_NONE, OUT_ACC, OUT_ZERO} t_out_mode;
    typedef enum logic [2:0] {C_ALWAYS, C_START, C_CLR_END, C_K_GT1, C_LO_LT_HI} t_cond;

    typedef struct packed {
        t_rd_mode  rd;
        t_wr_mode  wr;
        t_k_mode   kop;
        t_acc_mode acc;
        t_out_mode out;
        t_cond     cond;
        t_step     t_true;
        t_step     t_false;
    } t_uword;

    // control store: one word per step
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        w = '{RD_NONE, WR_NONE, K_HOLD, ACC_HOLD, OUT_NONE, C_ALWAYS, ST_IDLE, ST_IDLE};
        case (pc)
            ST_CLR: begin
                w = '{RD_NONE, WR_CLR, K_INC, ACC_HOLD, OUT_NONE, C_CLR_END,
                      ST_IDLE, ST_CLR};
            end
            ST_IDLE: begin
                // taken target comes from the op dispatch
                w = '{RD_NONE, WR_NONE, K_LOAD, ACC_LOAD, OUT_NONE, C_START,
                      ST_IDLE, ST_IDLE};
            end
            ST_SET_WR: begin
                w = '{RD_NONE, WR_LEAF, K_HOLD, ACC_HOLD, OUT_NONE, C_ALWAYS,
                      ST_SET_TST, ST_SET_TST};
            end
            ST_SET_TST: begin
                w = '{RD_SIB, WR_NONE, K_HOLD, ACC_HOLD, OUT_NONE, C_K_GT1,
                      ST_SET_UPD, ST_FIN_Z};
            end
            ST_SET_UPD: begin
                w = '{RD_NONE, WR_SET, K_HALF, ACC_SET, OUT_NONE, C_ALWAYS,
                      ST_SET_TST, ST_SET_TST};
            end
            ST_Q_TST: begin
                w = '{RD_Q, WR_NONE, K_HOLD, ACC_HOLD, OUT_NONE, C_LO_LT_HI,
                      ST_Q_ADD, ST_FIN};
            end
            ST_Q_ADD: begin
                w = '{RD_NONE, WR_NONE, K_QSTEP, ACC_Q, OUT_NONE, C_ALWAYS,
                      ST_Q_TST, ST_Q_TST};
            end
            ST_B_TST: begin
                w = '{RD_B, WR_NONE, K_HOLD, ACC_HOLD, OUT_NONE, C_K_GT1,
                      ST_B_WR, ST_FIN_Z};
            end
            ST_B_WR: begin
                w = '{RD_NONE, WR_BLD, K_DEC, ACC_HOLD, OUT_NONE, C_ALWAYS,
                      ST_B_TST, ST_B_TST};
            end
            ST_FIN: begin
                w = '{RD_NONE, WR_NONE, K_HOLD, ACC_HOLD, OUT_ACC, C_ALWAYS,
                      ST_IDLE, ST_IDLE};
            end
            ST_FIN_Z: begin
                w = '{RD_NONE, WR_NONE, K_HOLD, ACC_HOLD, OUT_ZERO, C_ALWAYS,
                      ST_IDLE, ST_IDLE};
            end
            default: begin
                w = '{RD_NONE, WR_NONE, K_HOLD, ACC_HOLD, OUT_NONE, C_ALWAYS,
                      ST_IDLE, ST_IDLE};
            end
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/sst_ram.sv]
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= mem[i_raddr0];
        o_rdata1 <= mem[i_raddr1];
    end

endmodule

[hw/rtl/sum_segment_tree_unit.sv]
// each tree level is one node store read plus one add or write: a set writes the leaf and
// then walks up the levels above it; a query walks the levels from both ends of its range;
// a rebuild writes each internal node from its two children; rejected ops return zero
// throughput: one op at a time, the next op is taken at the edge that ends a result beat
// reset: synchronous, active low; the node store is then cleared, all 2048 nodes, with
// busy high; config writes are taken at any time; the receiver cannot stall results
module sum_segment_tree_unit
    import sst_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_op,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_leaf_value,
    input  logic [POS_W-1:0]         i_range_low,
    input  logic [LC_W-1:0]          i_range_high,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [LC_W-1:0]          i_cfg_data,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_range_sum,
    output logic                     o_error
);

    t_step              r_pc, n_pc;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0]   r_hi, n_hi;
    logic [DATA_W-1:0]  r_acc, n_acc;
    logic               r_err, n_err;
    logic [LC_W-1:0]    r_leaf_count;
    logic               r_valid;
    logic [DATA_W-1:0]  r_sum;
    logic               r_out_err;

    t_uword             uw;
    logic               accept;
    logic [LC_W-1:0]    n_eff;
    logic [IDX_W-1:0]   n_ext;
    logic               disp_err;
    t_step              disp_pc;
    logic               cond_ok;

    logic               ram_we;
    logic [NODE_AW-1:0] ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [NODE_AW-1:0] ram_raddr0;
    logic [NODE_AW-1:0] ram_raddr1;
    logic [DATA_W-1:0]  ram_rdata0;
    logic [DATA_W-1:0]  ram_rdata1;

    logic [IDX_W-1:0]   k_dec;
    logic [IDX_W-1:0]   hi_dec;
    logic [DATA_W-1:0]  set_sum;
    logic [DATA_W-1:0]  bld_sum;
    logic [DATA_W-1:0]  q_add0;
    logic [DATA_W-1:0]  q_add1;

    sst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_store (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr0 (ram_raddr0),
        .i_raddr1 (ram_raddr1),
        .o_rdata0 (ram_rdata0),
        .o_rdata1 (ram_rdata1)
    );

    assign uw          = ucode(r_pc);
    assign busy        = (r_pc != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_range_sum = r_sum;
    assign o_error     = r_out_err;

    assign n_eff   = (r_leaf_count > LC_W'(MAX_LEAVES)) ? LC_W'(MAX_LEAVES) : r_leaf_count;
    assign n_ext   = IDX_W'(n_eff);
    assign k_dec   = r_k - IDX_W'(1);
    assign hi_dec  = r_hi - IDX_W'(1);
    assign set_sum = r_acc + ram_rdata0;
    assign bld_sum = ram_rdata0 + ram_rdata1;
    assign q_add0  = r_k[0] ? ram_rdata0 : '0;
    assign q_add1  = r_hi[0] ? ram_rdata1 : '0;

    // op check and dispatch target
    always_comb begin
        disp_err = 1'b0;
        disp_pc  = ST_FIN_Z;
        case (i_op)
            OP_SET: begin
                disp_err = (LC_W'(i_position) >= n_eff);
                disp_pc  = ST_SET_WR;
            end
            OP_QUERY: begin
                disp_err = (i_range_high > n_eff) || (LC_W'(i_range_low) > i_range_high);
                disp_pc  = ST_Q_TST;
            end
            OP_BUILD: begin
                disp_err = 1'b0;
                disp_pc  = ST_B_TST;
            end
            default: begin
                disp_err = 1'b1;
                disp_pc  = ST_FIN_Z;
            end
        endcase
        if (disp_err) begin
            disp_pc = ST_FIN_Z;
        end
    end

    always_comb begin
        case (uw.cond)
            C_ALWAYS:   cond_ok = 1'b1;
            C_START:    cond_ok = accept;
            C_CLR_END:  cond_ok = &r_k[NODE_AW-1:0];
            C_K_GT1:    cond_ok = (r_k > IDX_W'(1));
            C_LO_LT_HI: cond_ok = (r_k < r_hi);
            default:    cond_ok = 1'b0;
        endcase
        n_pc = cond_ok ? uw.t_true : uw.t_false;
        if (uw.cond == C_START && accept) begin
            n_pc = disp_pc;
        end
    end

    always_comb begin
        ram_raddr0 = '0;
        ram_raddr1 = '0;
        case (uw.rd)
            RD_SIB: begin
                ram_raddr0 = r_k[NODE_AW-1:0] ^ NODE_AW'(1);
            end
            RD_Q: begin
                ram_raddr0 = r_k[NODE_AW-1:0];
                ram_raddr1 = hi_dec[NODE_AW-1:0];
            end
            RD_B: begin
                // children of node k-1
                ram_raddr0 = {k_dec[NODE_AW-2:0], 1'b0};
                ram_raddr1 = {k_dec[NODE_AW-2:0], 1'b1};
            end
            default: begin
                ram_raddr0 = '0;
                ram_raddr1 = '0;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_k[NODE_AW-1:0];
        ram_wdata = '0;
        case (uw.wr)
            WR_CLR: begin
                ram_we = 1'b1;
            end
            WR_LEAF: begin
                ram_we    = 1'b1;
                ram_wdata = r_acc;
            end
            WR_SET: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[NODE_AW:1];
                ram_wdata = set_sum;
            end
            WR_BLD: begin
                ram_we    = 1'b1;
                ram_waddr = k_dec[NODE_AW-1:0];
                ram_wdata = bld_sum;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_k   = r_k;
        n_hi  = r_hi;
        n_acc = r_acc;
        n_err = r_err;
        case (uw.kop)
            K_INC:   n_k = r_k + IDX_W'(1);
            K_HALF:  n_k = r_k >> 1;
            K_DEC:   n_k = k_dec;
            K_QSTEP: begin
                n_k  = (r_k + IDX_W'(r_k[0])) >> 1;
                n_hi = (r_hi - IDX_W'(r_hi[0])) >> 1;
            end
            K_LOAD: begin
                if (accept) begin
                    case (i_op)
                        OP_SET:   n_k = n_ext + IDX_W'(i_position);
                        OP_QUERY: n_k = n_ext + IDX_W'(i_range_low);
                        default:  n_k = n_ext;
                    endcase
                    n_hi = n_ext + IDX_W'(i_range_high);
                end
            end
            default: n_k = r_k;
        endcase
        case (uw.acc)
            ACC_LOAD: begin
                if (accept) begin
                    n_acc = (i_op == OP_SET) ? i_leaf_value : '0;
                    n_err = disp_err;
                end
            end
            ACC_SET: n_acc = set_sum;
            ACC_Q:   n_acc = r_acc + q_add0 + q_add1;
            default: n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= ST_CLR;
            r_k          <= '0;
            r_leaf_count <= LEAF_COUNT_RESET;
            r_valid      <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_k     <= n_k;
            r_valid <= (uw.out != OUT_NONE);
            if (i_cfg_valid && o_cfg_ready) begin
                r_leaf_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_acc <= n_acc;
        r_err <= n_err;
        if (uw.out != OUT_NONE) begin
            r_sum     <= (uw.out == OUT_ACC) ? r_acc : '0;
            r_out_err <= r_err;
        end
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted op did not raise busy");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_range_sum == '0))
        else $error("rejected op returned a nonzero sum");

    a_bad_op_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op != OP_SET && i_op != OP_QUERY && i_op != OP_BUILD)
            |=> ##1 (o_valid && o_error))
        else $error("unused op not rejected in two cycles");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("store clearing pass not started after reset");

endmodule
